### rtl/gps_pkg.sv
// Shared types and constants of the goal point sequencer.
`timescale 1ns / 1ps
`default_nettype none

package gps_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 32;
    localparam int RAD_W      = 24;
    localparam int R2_W       = 2 * RAD_W;
    localparam int HEAD_W     = 16;
    localparam int VEL_W      = 16;
    localparam int SPD_W      = 32;
    localparam int NEAR_W     = 24;
    localparam int SQ_W       = 2 * NEAR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    localparam logic [SPD_W-1:0] STOP_THR_RST = 32'd168;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_VEL     = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_VEL  = 2'd0,
        KIND_GOAL = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // One table entry; the radius is kept squared.
    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [R2_W-1:0]          r2;
        logic signed [HEAD_W-1:0] w;
        logic signed [HEAD_W-1:0] z;
        logic                     hold_flag;
    } t_entry;

    // Slot and table activity decided by the commit stage this cycle.
    typedef struct packed {
        logic load;
        logic advance;
        logic restart;
    } t_move;

    typedef struct packed {
        logic            far;
        logic [SQ_W-1:0] dx2;
        logic [SQ_W-1:0] dy2;
        logic [R2_W-1:0] r2;
    } t_geo;

    typedef struct packed {
        t_op                     op;
        logic                    pose_valid;
        logic signed [VEL_W-1:0] lin;
        logic signed [VEL_W-1:0] ang;
        logic [SLOT_W-1:0]       eidx;
        t_entry                  ent;
        t_geo                    geo;
        logic [SPD_W-1:0]        lin_sq;
        logic [SPD_W-1:0]        ang_sq;
    } t_stage2;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VEL_W-1:0]  lin;
        logic signed [VEL_W-1:0]  ang;
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [HEAD_W-1:0] goal_w;
        logic signed [HEAD_W-1:0] goal_z;
        logic [SLOT_W-1:0]        slot;
    } t_result;

endpackage

`default_nettype wire

### rtl/gps_table.sv
// Route point memory with next-entry prefetch and current/first entry copies.
`timescale 1ns / 1ps
`default_nettype none

module gps_table
    import gps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_move         i_mv,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic [AW-1:0] i_cur_addr,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_cur,
    output t_entry             o_cur_fwd,
    output t_entry             o_nxt,
    output t_entry             o_e0
);

    t_entry r_mem [MAX_POINTS];
    t_entry r_rd;
    t_entry r_fwd_data;
    logic   r_fwd;
    t_entry r_cur;
    t_entry r_e0;

    always_ff @(posedge i_clk) begin
        if (i_mv.load) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // A load to the address being prefetched wins over the old memory word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_mv.load && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_wr_data;
    end

    assign o_nxt = r_fwd ? r_fwd_data : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_mv.advance) begin
            r_cur <= o_nxt;
        end else if (i_mv.restart) begin
            r_cur <= r_e0;
        end else if (i_mv.load && (i_wr_addr == i_cur_addr)) begin
            r_cur <= i_wr_data;
        end
        if (i_mv.load && (i_wr_addr == '0)) begin
            r_e0 <= i_wr_data;
        end
    end

    assign o_cur     = r_cur;
    assign o_cur_fwd = (i_mv.load && (i_wr_addr == i_cur_addr)) ? i_wr_data : r_cur;
    assign o_e0      = r_e0;

endmodule

`default_nettype wire

### rtl/gps_geom.sv
// Input register and distance stage: squares against the candidate goal entries.
`timescale 1ns / 1ps
`default_nettype none

module gps_geom
    import gps_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [SLOT_W-1:0]        i_entry_index,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic [RAD_W-1:0]         i_arrival_radius,
    input  wire logic                     i_wait_here,
    input  wire logic signed [HEAD_W-1:0] i_heading_w,
    input  wire logic signed [HEAD_W-1:0] i_heading_z,
    input  wire logic signed [VEL_W-1:0]  i_lin_in,
    input  wire logic signed [VEL_W-1:0]  i_ang_in,
    input  wire logic                     i_pose_valid,
    input  wire t_entry                   i_cur,
    input  wire t_entry                   i_nxt,
    input  wire t_entry                   i_e0,
    input  wire t_move                    i_mv,
    output logic                          o_s1_valid,
    output logic                          o_s2_valid,
    output t_stage2                       o_s2
);

    logic                     r_s1_valid;
    t_op                      r_s1_op;
    logic [SLOT_W-1:0]        r_s1_eidx;
    logic signed [POS_W-1:0]  r_s1_px;
    logic signed [POS_W-1:0]  r_s1_py;
    logic [RAD_W-1:0]         r_s1_rad;
    logic                     r_s1_hold;
    logic signed [HEAD_W-1:0] r_s1_w;
    logic signed [HEAD_W-1:0] r_s1_z;
    logic signed [VEL_W-1:0]  r_s1_lin;
    logic signed [VEL_W-1:0]  r_s1_ang;
    logic                     r_s1_pv;

    logic    r_s2_valid;
    t_stage2 r_s2;
    t_stage2 n_s2;

    t_geo g_cur;
    t_geo g_nxt;
    t_geo g_e0;
    logic signed [2*VEL_W-1:0] lin_sq;
    logic signed [2*VEL_W-1:0] ang_sq;

    function automatic logic [POS_W:0] f_abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic [POS_W:0]        u;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        u = d;
        f_abs_diff = d[POS_W] ? (~u + {{POS_W{1'b0}}, 1'b1}) : u;
    endfunction

    // Offsets of 256 m or more on an axis are outside without squaring.
    function automatic t_geo f_geo(input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py,
                                   input t_entry e);
        logic [POS_W:0]    ax;
        logic [POS_W:0]    ay;
        logic [NEAR_W-1:0] nx;
        logic [NEAR_W-1:0] ny;
        t_geo              g;
        ax    = f_abs_diff(px, e.x);
        ay    = f_abs_diff(py, e.y);
        nx    = ax[NEAR_W-1:0];
        ny    = ay[NEAR_W-1:0];
        g.far = (|ax[POS_W:NEAR_W]) || (|ay[POS_W:NEAR_W]);
        g.dx2 = nx * nx;
        g.dy2 = ny * ny;
        g.r2  = e.r2;
        return g;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_op   <= t_op'(i_opcode);
            r_s1_eidx <= i_entry_index;
            r_s1_px   <= i_pos_x;
            r_s1_py   <= i_pos_y;
            r_s1_rad  <= i_arrival_radius;
            r_s1_hold <= i_wait_here;
            r_s1_w    <= i_heading_w;
            r_s1_z    <= i_heading_z;
            r_s1_lin  <= i_lin_in;
            r_s1_ang  <= i_ang_in;
            r_s1_pv   <= i_pose_valid;
        end
        r_s2 <= n_s2;
    end

    // Evaluate every entry the slot may point to once the beat ahead commits.
    assign g_cur  = f_geo(r_s1_px, r_s1_py, i_cur);
    assign g_nxt  = f_geo(r_s1_px, r_s1_py, i_nxt);
    assign g_e0   = f_geo(r_s1_px, r_s1_py, i_e0);
    assign lin_sq = r_s1_lin * r_s1_lin;
    assign ang_sq = r_s1_ang * r_s1_ang;

    always_comb begin
        n_s2               = r_s2;
        n_s2.op            = r_s1_op;
        n_s2.pose_valid    = r_s1_pv;
        n_s2.lin           = r_s1_lin;
        n_s2.ang           = r_s1_ang;
        n_s2.eidx          = r_s1_eidx;
        n_s2.ent.x         = r_s1_px;
        n_s2.ent.y         = r_s1_py;
        n_s2.ent.r2        = r_s1_rad * r_s1_rad;
        n_s2.ent.w         = r_s1_w;
        n_s2.ent.z         = r_s1_z;
        n_s2.ent.hold_flag = r_s1_hold;
        n_s2.lin_sq        = lin_sq;
        n_s2.ang_sq        = ang_sq;
        if (i_mv.advance) begin
            n_s2.geo = g_nxt;
        end else if (i_mv.restart) begin
            n_s2.geo = g_e0;
        end else begin
            n_s2.geo = g_cur;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

`default_nettype wire

### rtl/gps_seq.sv
// Commit stage: route state, configuration registers and result forming.
`timescale 1ns / 1ps
`default_nettype none

module gps_seq
    import gps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_s2_valid,
    input  wire t_stage2               i_s2,
    input  wire t_entry                i_cur,
    input  wire t_entry                i_nxt,
    input  wire t_entry                i_e0,
    output t_move                      o_mv,
    output logic [AW-1:0]              o_wr_addr,
    output t_entry                     o_wr_data,
    output logic [AW-1:0]              o_cur_addr,
    output logic [AW-1:0]              o_rd_addr,
    output logic                       o_push,
    output t_result                    o_res
);

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_holding;
    logic              n_holding;
    logic              r_finished;
    logic              n_finished;
    logic [SPD_W-1:0]  r_speed;
    logic [SPD_W-1:0]  n_speed;
    logic [CNT_W-1:0]  r_count;
    logic [SPD_W-1:0]  r_thr;

    logic [CNT_W-1:0]  cnt_eff;
    logic [SQ_W:0]     dist_sq;
    logic              inside_area;
    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] rd_slot;
    logic              more_points;
    logic [SPD_W-1:0]  speed_sum;

    function automatic logic [AW-1:0] f_addr(input logic [SLOT_W-1:0] s);
        logic [AW+SLOT_W-1:0] wide;
        wide = {{AW{1'b0}}, s};
        return wide[AW-1:0];
    endfunction

    function automatic t_result f_goal(input t_entry e, input logic [SLOT_W-1:0] s);
        t_result r;
        r        = '0;
        r.kind   = KIND_GOAL;
        r.goal_x = e.x;
        r.goal_y = e.y;
        r.goal_w = e.w;
        r.goal_z = e.z;
        r.slot   = s;
        return r;
    endfunction

    assign cnt_eff     = (int'(r_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : r_count;
    assign dist_sq     = {1'b0, i_s2.geo.dx2} + {1'b0, i_s2.geo.dy2};
    assign inside_area = !i_s2.geo.far && (dist_sq < {1'b0, i_s2.geo.r2});
    assign slot_inc    = r_slot + SLOT_W'(1);
    assign more_points = ({1'b0, r_slot} + CNT_W'(1)) < cnt_eff;
    assign speed_sum   = i_s2.lin_sq + i_s2.ang_sq;

    always_comb begin
        n_slot     = r_slot;
        n_holding  = r_holding;
        n_finished = r_finished;
        n_speed    = r_speed;
        o_mv       = '0;
        o_push     = 1'b0;
        o_res      = '0;
        if (i_s2_valid) begin
            unique case (i_s2.op)
                OP_LOAD: begin
                    o_mv.load = int'(i_s2.eidx) < MAX_POINTS;
                end
                OP_VEL: begin
                    o_push     = 1'b1;
                    o_res.kind = KIND_VEL;
                    o_res.lin  = r_holding ? '0 : i_s2.lin;
                    o_res.ang  = r_holding ? '0 : i_s2.ang;
                    n_speed    = r_holding ? '0 : speed_sum;
                end
                OP_RESTART: begin
                    n_holding    = 1'b0;
                    n_finished   = 1'b0;
                    n_slot       = '0;
                    o_mv.restart = 1'b1;
                    if (cnt_eff != '0) begin
                        o_push = 1'b1;
                        o_res  = f_goal(i_e0, '0);
                    end
                end
                OP_TICK: begin
                    if (!r_finished && (cnt_eff != '0) && i_s2.pose_valid) begin
                        if (!inside_area) begin
                            // stopped short of the point: send the goal again
                            if ((r_speed < r_thr) && !r_holding) begin
                                o_push = 1'b1;
                                o_res  = f_goal(i_cur, r_slot);
                            end
                        end else if (more_points) begin
                            n_holding    = i_cur.hold_flag;
                            n_slot       = slot_inc;
                            o_mv.advance = 1'b1;
                            o_push       = 1'b1;
                            o_res        = f_goal(i_nxt, slot_inc);
                        end else begin
                            n_finished = 1'b1;
                            o_push     = 1'b1;
                            o_res.kind = KIND_DONE;
                        end
                    end
                end
            endcase
        end
    end

    // Prefetch the entry after the slot that holds from the next cycle on.
    assign rd_slot    = n_slot + SLOT_W'(1);
    assign o_rd_addr  = (int'(rd_slot) < MAX_POINTS) ? f_addr(rd_slot) : '0;
    assign o_cur_addr = f_addr(r_slot);
    assign o_wr_addr  = f_addr(i_s2.eidx);
    assign o_wr_data  = i_s2.ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_holding  <= 1'b0;
            r_finished <= 1'b0;
            r_speed    <= '0;
        end else begin
            r_slot     <= n_slot;
            r_holding  <= n_holding;
            r_finished <= n_finished;
            r_speed    <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_thr   <= STOP_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POINT_COUNT:    r_count <= i_cfg_data[CNT_W-1:0];
                CFG_STOP_THRESHOLD: r_thr   <= i_cfg_data[SPD_W-1:0];
            endcase
        end
    end

    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s2_valid && (i_s2.op == OP_TICK) && r_finished) |-> !o_push)
        else $error("tick produced a result after the route was finished");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s2_valid && (i_s2.op == OP_VEL) && r_holding)
            |-> (o_push && (o_res.lin == '0) && (o_res.ang == '0)))
        else $error("velocity passed while holding");

    a_advance_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mv.advance |=> (r_slot == $past(slot_inc)) && !r_finished)
        else $error("advance did not move to the following slot");

endmodule

`default_nettype wire

### rtl/gps_result_fifo.sv
// Small result queue between the commit stage and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module gps_result_fifo
    import gps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_result               i_res,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_result                    o_res,
    output logic [RES_CNT_W-1:0]       o_count
);

    t_result               r_buf [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr_ptr;
    logic [RES_PTR_W-1:0]  r_rd_ptr;
    logic [RES_CNT_W-1:0]  r_cnt;
    logic                  pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_buf[r_rd_ptr];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_cnt <= r_cnt + RES_CNT_W'(i_push) - RES_CNT_W'(pop);
        end
    end

    // Input credit keeps a slot free for every beat still in the pipe.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < RES_CNT_W'(RES_DEPTH)))
        else $error("result pushed into a full queue");

endmodule

`default_nettype wire

### rtl/goal_point_sequencer.sv
// Top level of the goal point sequencer.
//
// Takes one input beat per clock while o_in_stall is low and gives its
// result, if any, through the input register, the distance stage and the
// commit stage. The rate is set by the slot dependence between pose ticks:
// the distance stage squares the pose offset against the current, the next
// and the first entry at once, and the commit stage picks the one that the
// beat ahead leaves in place, so ticks that advance in consecutive cycles
// need no wait. The route table is one memory with a registered read that
// always prefetches the entry after the current slot. Results queue four
// deep; o_in_stall rises when queued plus in-flight results reach four, so a
// stalled output stops the input only after that. There is no clearing pass:
// table entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module goal_point_sequencer
    import gps_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [SLOT_W-1:0]        i_entry_index,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic [RAD_W-1:0]         i_arrival_radius,
    input  wire logic                     i_wait_here,
    input  wire logic signed [HEAD_W-1:0] i_heading_w,
    input  wire logic signed [HEAD_W-1:0] i_heading_z,
    input  wire logic signed [VEL_W-1:0]  i_lin_in,
    input  wire logic signed [VEL_W-1:0]  i_ang_in,
    input  wire logic                     i_pose_valid,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [1:0]                    o_result_kind,
    output logic signed [VEL_W-1:0]       o_lin_out,
    output logic signed [VEL_W-1:0]       o_ang_out,
    output logic signed [POS_W-1:0]       o_goal_x,
    output logic signed [POS_W-1:0]       o_goal_y,
    output logic signed [HEAD_W-1:0]      o_goal_w,
    output logic signed [HEAD_W-1:0]      o_goal_z,
    output logic [SLOT_W-1:0]             o_goal_slot
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic                 in_accept;
    logic                 s1_valid;
    logic                 s2_valid;
    t_stage2              s2;
    t_move                mv;
    logic [AW-1:0]        wr_addr;
    t_entry               wr_data;
    logic [AW-1:0]        cur_addr;
    logic [AW-1:0]        rd_addr;
    t_entry               cur;
    t_entry               cur_fwd;
    t_entry               nxt;
    t_entry               e0;
    logic                 push;
    t_result              res_in;
    t_result              res_out;
    logic [RES_CNT_W-1:0] res_cnt;
    logic [RES_CNT_W-1:0] busy;

    // Count queued results plus beats that may still produce one.
    assign busy       = res_cnt + RES_CNT_W'(s1_valid) + RES_CNT_W'(s2_valid);
    assign o_in_stall = busy >= RES_CNT_W'(RES_DEPTH);
    assign in_accept  = i_in_valid && !o_in_stall;

    gps_geom u_geom (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_arrival_radius (i_arrival_radius),
        .i_wait_here      (i_wait_here),
        .i_heading_w      (i_heading_w),
        .i_heading_z      (i_heading_z),
        .i_lin_in         (i_lin_in),
        .i_ang_in         (i_ang_in),
        .i_pose_valid     (i_pose_valid),
        .i_cur            (cur_fwd),
        .i_nxt            (nxt),
        .i_e0             (e0),
        .i_mv             (mv),
        .o_s1_valid       (s1_valid),
        .o_s2_valid       (s2_valid),
        .o_s2             (s2)
    );

    gps_table #(
        .MAX_POINTS (MAX_POINTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mv       (mv),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_cur_addr (cur_addr),
        .i_rd_addr  (rd_addr),
        .o_cur      (cur),
        .o_cur_fwd  (cur_fwd),
        .o_nxt      (nxt),
        .o_e0       (e0)
    );

    gps_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s2_valid  (s2_valid),
        .i_s2        (s2),
        .i_cur       (cur),
        .i_nxt       (nxt),
        .i_e0        (e0),
        .o_mv        (mv),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_cur_addr  (cur_addr),
        .o_rd_addr   (rd_addr),
        .o_push      (push),
        .o_res       (res_in)
    );

    gps_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res_out),
        .o_count (res_cnt)
    );

    assign o_result_kind = res_out.kind;
    assign o_lin_out     = res_out.lin;
    assign o_ang_out     = res_out.ang;
    assign o_goal_x      = res_out.goal_x;
    assign o_goal_y      = res_out.goal_y;
    assign o_goal_w      = res_out.goal_w;
    assign o_goal_z      = res_out.goal_z;
    assign o_goal_slot   = res_out.slot;

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the goal point sequencer: directed routes, then random traffic.
`timescale 1ns / 1ps

module tb;
    import gps_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int HOLD_OFF       = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEG_ITEMS      = 50;
    localparam int SEGMENTS       = 5;
    localparam int OVER_COUNT     = 100;
    localparam int MAX_PRINTS     = 50;

    typedef struct {
        t_op                      op;
        logic [SLOT_W-1:0]        eidx;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic [RAD_W-1:0]         rad;
        logic                     wt;
        logic signed [HEAD_W-1:0] hw;
        logic signed [HEAD_W-1:0] hz;
        logic signed [VEL_W-1:0]  lin;
        logic signed [VEL_W-1:0]  ang;
        logic                     pv;
    } t_beat;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_opcode;
    logic [SLOT_W-1:0]        i_entry_index;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic [RAD_W-1:0]         i_arrival_radius;
    logic                     i_wait_here;
    logic signed [HEAD_W-1:0] i_heading_w;
    logic signed [HEAD_W-1:0] i_heading_z;
    logic signed [VEL_W-1:0]  i_lin_in;
    logic signed [VEL_W-1:0]  i_ang_in;
    logic                     i_pose_valid;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_result_kind;
    logic signed [VEL_W-1:0]  o_lin_out;
    logic signed [VEL_W-1:0]  o_ang_out;
    logic signed [POS_W-1:0]  o_goal_x;
    logic signed [POS_W-1:0]  o_goal_y;
    logic signed [HEAD_W-1:0] o_goal_w;
    logic signed [HEAD_W-1:0] o_goal_z;
    logic [SLOT_W-1:0]        o_goal_slot;

    goal_point_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_arrival_radius (i_arrival_radius),
        .i_wait_here      (i_wait_here),
        .i_heading_w      (i_heading_w),
        .i_heading_z      (i_heading_z),
        .i_lin_in         (i_lin_in),
        .i_ang_in         (i_ang_in),
        .i_pose_valid     (i_pose_valid),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_lin_out        (o_lin_out),
        .o_ang_out        (o_ang_out),
        .o_goal_x         (o_goal_x),
        .o_goal_y         (o_goal_y),
        .o_goal_w         (o_goal_w),
        .o_goal_z         (o_goal_z),
        .o_goal_slot      (o_goal_slot)
    );

    // Route state as the block should hold it.
    logic signed [POS_W-1:0]  tab_x    [TABLE_DEPTH];
    logic signed [POS_W-1:0]  tab_y    [TABLE_DEPTH];
    logic [RAD_W-1:0]         tab_r    [TABLE_DEPTH];
    logic signed [HEAD_W-1:0] tab_hw   [TABLE_DEPTH];
    logic signed [HEAD_W-1:0] tab_hz   [TABLE_DEPTH];
    bit                       tab_wait [TABLE_DEPTH];
    bit                       loaded   [TABLE_DEPTH];
    logic [SLOT_W-1:0]        cur_slot;
    bit                       holding;
    bit                       finished;
    logic [SPD_W-1:0]         speed_sq;
    logic [CNT_W-1:0]         point_count;
    logic [SPD_W-1:0]         stop_thr;

    t_result route_due [$];
    t_result want_res;
    int      errors;
    int      in_idle_pct;
    int      out_stall_pct;
    int      idle_cycles;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic int live_points();
        return (point_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(point_count);
    endfunction

    function automatic t_result goal_of(input logic [SLOT_W-1:0] slot);
        t_result r;
        r        = '0;
        r.kind   = KIND_GOAL;
        r.goal_x = tab_x[slot];
        r.goal_y = tab_y[slot];
        r.goal_w = tab_hw[slot];
        r.goal_z = tab_hz[slot];
        r.slot   = slot;
        return r;
    endfunction

    // Append one beat to the list of results still owed by the block.
    function automatic void queue_result(input t_result r);
        route_due = {route_due, r};
    endfunction

    function automatic bit in_arrival_zone(input logic [SLOT_W-1:0] idx,
                                           input logic signed [POS_W-1:0] px,
                                           input logic signed [POS_W-1:0] py);
        longint dx;
        longint dy;
        longint r;
        dx = longint'(px) - longint'(tab_x[idx]);
        dy = longint'(py) - longint'(tab_y[idx]);
        r  = longint'(tab_r[idx]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // Offsets of 256 m or more never count as inside.
        if (dx >= 64'sd16777216 || dy >= 64'sd16777216)
            return 1'b0;
        return (dx * dx + dy * dy) < (r * r);
    endfunction

    task automatic advance_route(input t_beat b);
        t_result r;
        longint  l;
        longint  a;
        int      n;
        r = '0;
        n = live_points();
        case (b.op)
            OP_LOAD: begin
                tab_x[b.eidx]    = b.px;
                tab_y[b.eidx]    = b.py;
                tab_r[b.eidx]    = b.rad;
                tab_hw[b.eidx]   = b.hw;
                tab_hz[b.eidx]   = b.hz;
                tab_wait[b.eidx] = b.wt;
                loaded[b.eidx]   = 1'b1;
            end
            OP_VEL: begin
                l        = holding ? 0 : longint'(b.lin);
                a        = holding ? 0 : longint'(b.ang);
                speed_sq = SPD_W'(l * l + a * a);
                r.kind   = KIND_VEL;
                r.lin    = VEL_W'(l);
                r.ang    = VEL_W'(a);
                queue_result(r);
            end
            OP_RESTART: begin
                holding  = 1'b0;
                finished = 1'b0;
                cur_slot = '0;
                if (n != 0)
                    queue_result(goal_of('0));
            end
            OP_TICK: begin
                if (!finished && n != 0 && b.pv) begin
                    if (!in_arrival_zone(cur_slot, b.px, b.py)) begin
                        // Stopped short of the point: send the goal again.
                        if (speed_sq < stop_thr && !holding)
                            queue_result(goal_of(cur_slot));
                    end else if (int'(cur_slot) + 1 < n) begin
                        holding  = tab_wait[cur_slot];
                        cur_slot = cur_slot + SLOT_W'(1);
                        queue_result(goal_of(cur_slot));
                    end else begin
                        finished = 1'b1;
                        r.kind   = KIND_DONE;
                        queue_result(r);
                    end
                end
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_due.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: unexpected beat, expected none got kind %0d",
                             $time, o_result_kind);
            end else begin
                want_res = route_due.pop_front();
                check_field("result_kind", want_res.kind, o_result_kind);
                check_field("lin_out", want_res.lin, o_lin_out);
                check_field("ang_out", want_res.ang, o_ang_out);
                check_field("goal_x", want_res.goal_x, o_goal_x);
                check_field("goal_y", want_res.goal_y, o_goal_y);
                check_field("goal_w", want_res.goal_w, o_goal_w);
                check_field("goal_z", want_res.goal_z, o_goal_z);
                check_field("goal_slot", want_res.slot, o_goal_slot);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic push_beat(input t_beat b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= b.op;
        i_entry_index    <= b.eidx;
        i_pos_x          <= b.px;
        i_pos_y          <= b.py;
        i_arrival_radius <= b.rad;
        i_wait_here      <= b.wt;
        i_heading_w      <= b.hw;
        i_heading_z      <= b.hz;
        i_lin_in         <= b.lin;
        i_ang_in         <= b.ang;
        i_pose_valid     <= b.pv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_route(b);
    endtask

    // Drop valid, drain every expected beat, then let the pipeline empty.
    task automatic settle_route();
        i_in_valid <= 1'b0;
        while (route_due.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_POINT_COUNT)
            point_count = val[CNT_W-1:0];
        else
            stop_thr = val;
    endtask

    task automatic set_route(input int count, input logic [SPD_W-1:0] thr);
        settle_route();
        write_reg(CFG_POINT_COUNT, count);
        write_reg(CFG_STOP_THRESHOLD, thr);
    endtask

    function automatic t_beat noise_beat();
        t_beat b;
        b.op   = t_op'($urandom_range(3));
        b.eidx = SLOT_W'($urandom);
        b.px   = $urandom;
        b.py   = $urandom;
        b.rad  = RAD_W'($urandom);
        b.wt   = 1'($urandom);
        b.hw   = HEAD_W'($urandom);
        b.hz   = HEAD_W'($urandom);
        b.lin  = VEL_W'($urandom);
        b.ang  = VEL_W'($urandom);
        b.pv   = 1'($urandom);
        return b;
    endfunction

    function automatic t_beat load_of(input int slot, input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic [RAD_W-1:0] rad, input logic wt,
                                      input logic signed [HEAD_W-1:0] hw,
                                      input logic signed [HEAD_W-1:0] hz);
        t_beat b;
        b      = noise_beat();
        b.op   = OP_LOAD;
        b.eidx = SLOT_W'(slot);
        b.px   = x;
        b.py   = y;
        b.rad  = rad;
        b.wt   = wt;
        b.hw   = hw;
        b.hz   = hz;
        return b;
    endfunction

    function automatic t_beat tick_at(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y, input logic pv);
        t_beat b;
        b    = noise_beat();
        b.op = OP_TICK;
        b.px = x;
        b.py = y;
        b.pv = pv;
        return b;
    endfunction

    function automatic t_beat vel_of(input logic signed [VEL_W-1:0] lin,
                                     input logic signed [VEL_W-1:0] ang);
        t_beat b;
        b     = noise_beat();
        b.op  = OP_VEL;
        b.lin = lin;
        b.ang = ang;
        return b;
    endfunction

    function automatic t_beat restart_beat();
        t_beat b;
        b    = noise_beat();
        b.op = OP_RESTART;
        return b;
    endfunction

    function automatic t_beat load_beat(input int slot);
        t_beat b;
        int    mode;
        b      = noise_beat();
        b.op   = OP_LOAD;
        b.eidx = SLOT_W'(slot);
        b.wt   = ($urandom_range(3) == 0);
        if ($urandom_range(1)) begin
            b.px = int'($urandom_range(0, 1 << 22)) - (1 << 21);
            b.py = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        end
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3, 4: b.rad = RAD_W'($urandom_range(1 << 12, 1 << 18));
            7:             b.rad = '0;
            8:             b.rad = '1;
            9:             b.rad = RAD_W'(1);
            default:       ;
        endcase
        return b;
    endfunction

    function automatic t_beat vel_beat();
        t_beat b;
        int    mode;
        b    = noise_beat();
        b.op = OP_VEL;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2: begin
                b.lin = '0;
                b.ang = '0;
            end
            // Near the stop threshold.
            3, 4, 5: begin
                b.lin = VEL_W'(int'($urandom_range(0, 24)) - 12);
                b.ang = VEL_W'(int'($urandom_range(0, 24)) - 12);
            end
            6: begin
                b.lin = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
                b.ang = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            end
            default: ;
        endcase
        return b;
    endfunction

    // Aim the pose at the current goal: inside, on the rim, just out, or far.
    function automatic t_beat tick_beat();
        t_beat b;
        int    rad;
        int    ox;
        int    oy;
        int    tmp;
        int    mode;
        b    = noise_beat();
        b.op = OP_TICK;
        b.pv = ($urandom_range(9) != 0);
        if (live_points() == 0 || !loaded[cur_slot])
            return b;
        rad  = int'(tab_r[cur_slot]);
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3, 4: begin
                ox = $urandom_range(0, rad * 7 / 10);
                oy = $urandom_range(0, rad * 7 / 10);
            end
            5: begin
                ox = $urandom_range(1) ? rad : rad - 1;
                oy = 0;
            end
            6: begin
                ox = rad + int'($urandom_range(0, 1000));
                oy = $urandom_range(0, rad / 2);
            end
            7: begin
                ox = (1 << 24) - int'($urandom_range(0, 1));
                oy = $urandom_range(0, 100);
            end
            default: return b;
        endcase
        if ($urandom_range(1)) begin
            tmp = ox;
            ox  = oy;
            oy  = tmp;
        end
        if ($urandom_range(1)) ox = -ox;
        if ($urandom_range(1)) oy = -oy;
        b.px = tab_x[cur_slot] + ox;
        b.py = tab_y[cur_slot] + oy;
        return b;
    endfunction

    function automatic t_beat pick_beat();
        int sel;
        sel = $urandom_range(99);
        if (live_points() == 0 || finished) begin
            if (sel < 10)      return load_beat($urandom_range(TABLE_DEPTH - 1));
            else if (sel < 55) return vel_beat();
            else if (sel < 70) return tick_beat();
            else               return restart_beat();
        end
        if (sel < 3)       return noise_beat();
        else if (sel < 10) return load_beat($urandom_range(TABLE_DEPTH - 1));
        else if (sel < 35) return vel_beat();
        else if (sel < 95) return tick_beat();
        else               return restart_beat();
    endfunction

    // Fill every slot that a route of this length would read.
    task automatic fill_route(input int count);
        int i;
        for (i = 0; i < count && i < TABLE_DEPTH; i++) begin
            if (!loaded[i])
                push_beat(load_beat(i));
        end
    endtask

    task automatic test_empty_route();
        push_beat(vel_of(16'sh8000, 16'sh8000));
        push_beat(vel_of(16'sh7FFF, 16'sh0000));
        push_beat(tick_at(32'sh0, 32'sh0, 1'b1));
        push_beat(restart_beat());
        push_beat(vel_of(16'sh0000, 16'sh0000));
    endtask

    task automatic test_route_walk();
        push_beat(load_of(0, 32'sh0, 32'sh0, 24'h01_0000, 1'b0, 16'sh7FFF, 16'sh8000));
        push_beat(load_of(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF, 1'b1,
                          16'sh8000, 16'sh7FFF));
        push_beat(load_of(2, 32'shFFFB_0000, 32'sh0003_0000, 24'h0, 1'b0, 16'sh0, 16'sh0));
        push_beat(load_of(3, 32'sh000A_0000, 32'sh000A_0000, 24'h02_0000, 1'b0,
                          16'sh4000, -16'sh4000));
        set_route(4, STOP_THR_RST);
        push_beat(restart_beat());
        push_beat(tick_at(32'sh0000_8000, 32'sh0, 1'b1));
        // Exactly on the rim of the widest radius: not yet arrived.
        push_beat(tick_at(32'sh7F00_0000, 32'sh8000_0000, 1'b1));
        push_beat(tick_at(32'sh7F00_0001, 32'sh8000_0000, 1'b1));
        push_beat(vel_of(16'sh1000, -16'sh1000));
        push_beat(tick_at(32'sh00FB_0000, 32'sh0003_0000, 1'b1));
        push_beat(tick_at(32'shFFFB_0000, 32'sh0003_0000, 1'b0));
        push_beat(tick_at(32'shFFFB_0000, 32'sh0003_0000, 1'b1));
        push_beat(load_of(2, 32'shFFFB_0000, 32'sh0003_0000, 24'h1, 1'b0,
                          16'sh2000, 16'sh1000));
        push_beat(tick_at(32'shFFFB_0000, 32'sh0003_0000, 1'b1));
        push_beat(vel_of(16'sh0005, 16'sh0005));
        push_beat(tick_at(32'sh0, 32'sh0, 1'b1));
        push_beat(tick_at(32'sh000A_0000, 32'sh000A_0000, 1'b1));
        push_beat(tick_at(32'sh000A_0000, 32'sh000A_0000, 1'b1));
        push_beat(restart_beat());
    endtask

    // Shrink the route under a slot that is past its new end.
    task automatic test_shrunk_count();
        push_beat(tick_at(32'sh0, 32'sh0, 1'b1));
        push_beat(tick_at(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
        set_route(2, STOP_THR_RST);
        push_beat(tick_at(32'shFFFB_0000, 32'sh0003_0000, 1'b1));
        push_beat(restart_beat());
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct);
        int               sel;
        int               count;
        logic [SPD_W-1:0] thr;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        repeat (SEGMENTS) begin
            sel = $urandom_range(9);
            if (sel < 7)       count = $urandom_range(1, 8);
            else if (sel == 7) count = TABLE_DEPTH;
            else if (sel == 8) count = OVER_COUNT;
            else               count = $urandom_range(0, TABLE_DEPTH);
            sel = $urandom_range(9);
            case (sel)
                0:       thr = '0;
                1:       thr = STOP_THR_RST;
                2:       thr = 32'h8000_0000;
                3, 4:    thr = $urandom_range(0, 4096);
                default: thr = $urandom_range(0, 32'h8000_0000);
            endcase
            fill_route(count);
            set_route(count, thr);
            repeat (SEG_ITEMS) push_beat(pick_beat());
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_out_stall      = 1'b0;
        i_opcode         = '0;
        i_entry_index    = '0;
        i_pos_x          = '0;
        i_pos_y          = '0;
        i_arrival_radius = '0;
        i_wait_here      = 1'b0;
        i_heading_w      = '0;
        i_heading_z      = '0;
        i_lin_in         = '0;
        i_ang_in         = '0;
        i_pose_valid     = 1'b0;
        errors           = 0;
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        idle_cycles      = 0;
        cur_slot         = '0;
        holding          = 1'b0;
        finished         = 1'b0;
        speed_sq         = '0;
        point_count      = '0;
        stop_thr         = STOP_THR_RST;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_route();
        test_route_walk();
        test_shrunk_count();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(20, 20);
        settle_route();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gps_pkg.sv
rtl/gps_table.sv
rtl/gps_geom.sv
rtl/gps_seq.sv
rtl/gps_result_fifo.sv
rtl/goal_point_sequencer.sv
test/tb.sv
